[rtl/assert_macros.svh]
// Assertion helpers shared by the parser modules.
// Both expect a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle property, ignored while reset is asserted.
`define ILP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define ILP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[rtl/ilp_pkg.sv]
`default_nettype none

package ilp_pkg;

  // Result type codes
  localparam logic [3:0] TC_NONE  = 4'd0;
  localparam logic [3:0] TC_I8    = 4'd1;
  localparam logic [3:0] TC_I16   = 4'd2;
  localparam logic [3:0] TC_I32   = 4'd3;
  localparam logic [3:0] TC_I64   = 4'd4;
  localparam logic [3:0] TC_U8    = 4'd5;
  localparam logic [3:0] TC_U16   = 4'd6;
  localparam logic [3:0] TC_U32   = 4'd7;
  localparam logic [3:0] TC_U64   = 4'd8;
  localparam logic [3:0] TC_ISIZE = 4'd9;
  localparam logic [3:0] TC_USIZE = 4'd10;
  localparam logic [3:0] TC_MAX   = TC_USIZE;

  // Literal state at its last character, handed to the range check.
  typedef struct packed {
    logic        ok;        // syntax, digits, overflow, suffix and forced code all fine
    logic [3:0]  sfx_type;  // type named by the suffix, TC_NONE if none
    logic [3:0]  held;      // forced type sampled on the first character
    logic        neg;
    logic [63:0] mag;
  } ilp_snap_t;

endpackage

`default_nettype wire

[rtl/ilp_scan.sv]
`default_nettype none
`include "assert_macros.svh"

// Character scanner: per-literal state and its one-character update.
module ilp_scan import ilp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic [7:0] ch,
  input  logic       last,
  input  logic [3:0] forced,
  output ilp_snap_t  snap
);

  typedef enum logic [2:0] {
    PH_START, PH_SIGN, PH_ZERO, PH_DIGITS, PH_SUF_I, PH_SUF_U
  } phase_t;

  typedef enum logic [3:0] {
    SF_NONE, SF_LETTER, SF_1, SF_3, SF_6, SF_8, SF_16, SF_32, SF_64,
    SF_S, SF_SI, SF_SIZ, SF_SZ, SF_SIZE, SF_BAD
  } sfx_t;

  typedef enum logic [1:0] {RX_DEC, RX_HEX, RX_BIN, RX_OCT} radix_t;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_4     = 8'h34;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UO    = 8'h4F;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LI    = 8'h69;
  localparam logic [7:0] CH_LO    = 8'h6F;
  localparam logic [7:0] CH_LS    = 8'h73;
  localparam logic [7:0] CH_LU    = 8'h75;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  function automatic sfx_t sfx_step(input sfx_t s, input logic [7:0] c);
    sfx_t r;
    r = SF_BAD;
    case (s)
      SF_LETTER: begin
        if (c == CH_1)      r = SF_1;
        else if (c == CH_3) r = SF_3;
        else if (c == CH_6) r = SF_6;
        else if (c == CH_8) r = SF_8;
        else if (c == CH_LS) r = SF_S;
      end
      SF_1:   if (c == CH_6) r = SF_16;
      SF_3:   if (c == CH_2) r = SF_32;
      SF_6:   if (c == CH_4) r = SF_64;
      SF_S: begin
        if (c == CH_LI)      r = SF_SI;
        else if (c == CH_LZ) r = SF_SZ;
      end
      SF_SI:  if (c == CH_LZ) r = SF_SIZ;
      SF_SIZ: if (c == CH_LE) r = SF_SIZE;
      default: r = SF_BAD;
    endcase
    return r;
  endfunction

  phase_t      phase, phase_next;
  radix_t      radix, radix_next;
  logic [63:0] mag, mag_next;
  logic        ovf, ovf_next;
  logic        neg, neg_next;
  logic        dseen, dseen_next;
  sfx_t        sfx, sfx_next;
  logic [3:0]  held, held_next;
  logic        serr, serr_next;

  logic [4:0]  dval;
  logic        dig_ok;
  logic [67:0] shifted;
  logic [67:0] prod;
  logic        take;
  logic        do_digits;

  // digit value, 16 for a non-digit
  always_comb begin
    if (ch >= CH_0 && ch <= CH_9) begin
      dval = {1'b0, ch[3:0]};
    end else if ((ch >= CH_LA && ch <= CH_LF) || (ch >= CH_UA && ch <= CH_UF)) begin
      dval = {1'b0, ch[3:0]} + 5'd9;
    end else begin
      dval = 5'd16;
    end
  end

  // one shift-add step of the accumulator; 68 bits expose overflow
  always_comb begin
    case (radix)
      RX_DEC: begin
        shifted = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0};
        dig_ok  = dval < 5'd10;
      end
      RX_HEX: begin
        shifted = {mag, 4'b0000};
        dig_ok  = dval < 5'd16;
      end
      RX_BIN: begin
        shifted = {3'b000, mag, 1'b0};
        dig_ok  = dval < 5'd2;
      end
      RX_OCT: begin
        shifted = {1'b0, mag, 3'b000};
        dig_ok  = dval < 5'd8;
      end
      default: begin
        shifted = '0;
        dig_ok  = 1'b0;
      end
    endcase
    prod = shifted + {63'd0, dval};
  end

  always_comb begin
    phase_next = phase;
    radix_next = radix;
    mag_next   = mag;
    ovf_next   = ovf;
    neg_next   = neg;
    dseen_next = dseen;
    sfx_next   = sfx;
    held_next  = (phase == PH_START) ? forced : held;
    serr_next  = serr;
    take       = 1'b0;
    do_digits  = 1'b0;

    case (phase)
      PH_START, PH_SIGN: begin
        if (phase == PH_START && ch == CH_MINUS) begin
          neg_next   = 1'b1;
          phase_next = PH_SIGN;
        end else if (ch == CH_0) begin
          take       = 1'b1;
          phase_next = PH_ZERO;
        end else if (ch >= CH_1 && ch <= CH_9) begin
          take       = 1'b1;
          phase_next = PH_DIGITS;
        end else begin
          serr_next = 1'b1;
        end
      end
      PH_ZERO: begin
        if (ch == CH_LX || ch == CH_UX) begin
          radix_next = RX_HEX;
        end else if (ch == CH_LB || ch == CH_UB) begin
          radix_next = RX_BIN;
        end else if (ch == CH_LO || ch == CH_UO) begin
          radix_next = RX_OCT;
        end else begin
          do_digits = 1'b1;
        end
        if (!do_digits) begin
          mag_next   = '0;
          dseen_next = 1'b0;
          phase_next = PH_DIGITS;
        end
      end
      PH_DIGITS: do_digits = 1'b1;
      PH_SUF_I, PH_SUF_U: sfx_next = sfx_step(sfx, ch);
      default: serr_next = 1'b1;
    endcase

    if (do_digits) begin
      if (dig_ok) begin
        take       = 1'b1;
        phase_next = PH_DIGITS;
      end else if ((ch == CH_LI || ch == CH_LU) && dseen) begin
        phase_next = (ch == CH_LI) ? PH_SUF_I : PH_SUF_U;
        sfx_next   = SF_LETTER;
      end else begin
        serr_next = 1'b1;
      end
    end

    if (take) begin
      mag_next   = prod[63:0];
      ovf_next   = ovf | (|prod[67:64]);
      dseen_next = 1'b1;
    end
  end

  // suffix decode on the updated state
  logic       is_suf;
  logic       is_i;
  logic [3:0] st;

  always_comb begin
    is_suf = (phase_next == PH_SUF_I) || (phase_next == PH_SUF_U);
    is_i   = (phase_next == PH_SUF_I);
    st     = TC_NONE;
    if (is_suf) begin
      case (sfx_next)
        SF_LETTER, SF_32: st = is_i ? TC_I32 : TC_U32;
        SF_8:             st = is_i ? TC_I8 : TC_U8;
        SF_16:            st = is_i ? TC_I16 : TC_U16;
        SF_64:            st = is_i ? TC_I64 : TC_U64;
        SF_SZ, SF_SIZE:   st = is_i ? TC_ISIZE : TC_USIZE;
        default:          st = TC_NONE;
      endcase
    end
    snap.ok       = !serr_next && dseen_next && !ovf_next && !(is_suf && st == TC_NONE)
                    && (held_next <= TC_MAX);
    snap.sfx_type = st;
    snap.held     = held_next;
    snap.neg      = neg_next;
    snap.mag      = mag_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (adv && last)) begin
      phase <= PH_START;
      radix <= RX_DEC;
      mag   <= '0;
      ovf   <= 1'b0;
      neg   <= 1'b0;
      dseen <= 1'b0;
      sfx   <= SF_NONE;
      held  <= TC_NONE;
      serr  <= 1'b0;
    end else if (adv) begin
      phase <= phase_next;
      radix <= radix_next;
      mag   <= mag_next;
      ovf   <= ovf_next;
      neg   <= neg_next;
      dseen <= dseen_next;
      sfx   <= sfx_next;
      held  <= held_next;
      serr  <= serr_next;
    end
  end

  `ILP_ASSERT_NEXT(a_rewind, adv && last, phase == PH_START && radix == RX_DEC && !serr && !dseen, "scanner did not rewind after last item")
  `ILP_ASSERT(a_suffix_digits, phase == PH_SUF_I || phase == PH_SUF_U |-> dseen, "suffix entered without digits")

endmodule

`default_nettype wire

[rtl/ilp_check.sv]
`default_nettype none

// Type resolution and range check of a finished literal.
module ilp_check import ilp_pkg::*; (
  input  ilp_snap_t   snap,
  output logic        ok,
  output logic [3:0]  tcode,
  output logic [63:0] value
);

  // signed n-bit: positive below 2^(n-1), negative down to -2^(n-1)
  function automatic logic fit_s(input logic [63:0] m, input logic ng, input logic [6:0] n);
    logic hi_zero;
    hi_zero = (m >> (n - 7'd1)) == 64'd0;
    return hi_zero || (ng && (m == (64'd1 << (n - 7'd1))));
  endfunction

  // unsigned n-bit, n below 64
  function automatic logic fit_u(input logic [63:0] m, input logic ng, input logic [6:0] n);
    return !ng && ((m >> n) == 64'd0);
  endfunction

  logic       ok1;
  logic [3:0] t;

  always_comb begin
    ok1 = snap.ok;
    t   = snap.sfx_type;
    if (ok1 && snap.held != TC_NONE) begin
      if (t != TC_NONE && t != snap.held) ok1 = 1'b0;
      t = snap.held;
    end
    if (ok1 && t == TC_NONE) begin
      // no suffix, no forced type: smallest of i32, i64, u64
      if (snap.neg) begin
        if (fit_s(snap.mag, 1'b1, 7'd32))      t = TC_I32;
        else if (fit_s(snap.mag, 1'b1, 7'd64)) t = TC_I64;
        else                                   ok1 = 1'b0;
      end else begin
        if (fit_s(snap.mag, 1'b0, 7'd32))      t = TC_I32;
        else if (fit_s(snap.mag, 1'b0, 7'd64)) t = TC_I64;
        else                                   t = TC_U64;
      end
    end else if (ok1) begin
      case (t)
        TC_I8:              ok1 = fit_s(snap.mag, snap.neg, 7'd8);
        TC_I16:             ok1 = fit_s(snap.mag, snap.neg, 7'd16);
        TC_I32:             ok1 = fit_s(snap.mag, snap.neg, 7'd32);
        TC_I64, TC_ISIZE:   ok1 = fit_s(snap.mag, snap.neg, 7'd64);
        TC_U8:              ok1 = fit_u(snap.mag, snap.neg, 7'd8);
        TC_U16:             ok1 = fit_u(snap.mag, snap.neg, 7'd16);
        TC_U32:             ok1 = fit_u(snap.mag, snap.neg, 7'd32);
        TC_U64, TC_USIZE:   ok1 = !snap.neg;
        default:            ok1 = 1'b0;
      endcase
    end

    ok    = ok1;
    tcode = ok1 ? t : TC_NONE;
    if (!ok1)          value = '0;
    else if (snap.neg) value = 64'd0 - snap.mag;
    else               value = snap.mag;
  end

endmodule

`default_nettype wire

[rtl/integer_literal_parser.sv]
// After its last character is accepted, a literal passes the input register, the
// finished-literal register and the result register. Throughput: one character per
// cycle while in_stall is low, set by the scanner loop that holds the shift-add.
// Reset (rst, synchronous, active high) empties all stages and returns the scanner
// to the start of a literal; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"

module integer_literal_parser import ilp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // character items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        last_char,
  input  logic [3:0]  forced_type,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic        valid_res,
  output logic [3:0]  type_code,
  output logic [63:0] value_bits
);

  // Pipeline:
  //   s1  input register holding one character item
  //   scan  per-literal state, updated as s1 drains
  //   s2  snapshot of a finished literal (only last characters land here)
  //   out result register, driven straight onto the output ports
  // Non-last characters leave s1 without waiting on the downstream stages,
  // so a stalled result never blocks characters of the next literal until
  // that literal's own last character arrives.

  logic       s1_vld;
  logic [7:0] s1_ch;
  logic       s1_last;
  logic [3:0] s1_forced;

  logic       s2_vld;
  ilp_snap_t  s2_snap;

  logic       s3_ready;
  logic       s2_ready;
  logic       s2_adv;
  logic       s2_load;
  logic       s1_adv;
  logic       s1_ready;

  ilp_snap_t   scan_snap;
  logic        chk_ok;
  logic [3:0]  chk_type;
  logic [63:0] chk_value;

  // flow control
  assign s3_ready = !out_valid || !out_stall;
  assign s2_ready = !s2_vld || s3_ready;
  assign s2_adv   = s2_vld && s3_ready;
  assign s1_adv   = s1_vld && (!s1_last || s2_ready);
  assign s2_load  = s1_adv && s1_last;
  assign s1_ready = !s1_vld || s1_adv;
  assign in_stall = !s1_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (s1_ready) begin
      s1_vld <= in_valid;
    end
    if (s1_ready && in_valid) begin
      s1_ch     <= char_code;
      s1_last   <= last_char;
      s1_forced <= forced_type;
    end
  end

  ilp_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .adv    (s1_adv),
    .ch     (s1_ch),
    .last   (s1_last),
    .forced (s1_forced),
    .snap   (scan_snap)
  );

  // finished-literal register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (s2_ready) begin
      s2_vld <= s2_load;
    end
    if (s2_load) begin
      s2_snap <= scan_snap;
    end
  end

  ilp_check u_check (
    .snap  (s2_snap),
    .ok    (chk_ok),
    .tcode (chk_type),
    .value (chk_value)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_ready) begin
      out_valid <= s2_vld;
    end
    if (s2_adv) begin
      valid_res  <= chk_ok;
      type_code  <= chk_type;
      value_bits <= chk_value;
    end
  end

  `ILP_ASSERT(a_invalid_zero, out_valid && !valid_res |-> type_code == TC_NONE && value_bits == 64'd0, "invalid result carries data")
  `ILP_ASSERT(a_valid_typed, out_valid && valid_res |-> type_code != TC_NONE && type_code <= TC_MAX, "valid result without a type")
  `ILP_ASSERT_NEXT(a_s2_hold, s2_vld && !s3_ready, s2_vld && $stable(s2_snap), "finished literal dropped while output stalled")

endmodule

`default_nettype wire
